@@ rtl/forest_fire_grid_step_assert.svh @@
// ----------------------------------------------------------------------------
// forest_fire_grid_step assertion macros
// shorthand for clocked implication checks, disabled during reset
// ----------------------------------------------------------------------------
`ifndef FOREST_FIRE_GRID_STEP_ASSERT_SVH
`define FOREST_FIRE_GRID_STEP_ASSERT_SVH

// same-cycle implication
`define FFGS_ASSERT_IMP(NAME, ANTE, CONS) \
  NAME: assert property (@(posedge clk) disable iff (rst) (ANTE) |-> (CONS)) \
    else $error("forest_fire_grid_step: implication check failed");

// next-cycle implication
`define FFGS_ASSERT_NXT(NAME, ANTE, CONS) \
  NAME: assert property (@(posedge clk) disable iff (rst) (ANTE) |=> (CONS)) \
    else $error("forest_fire_grid_step: next-cycle check failed");

`endif

@@ rtl/ffgs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ffgs_pkg
// types and constants of the forest fire grid block
// ----------------------------------------------------------------------------
package ffgs_pkg;

  localparam int ADDR_W = 6;
  localparam int CNT_W  = 15;
  localparam int TH_W   = 54;

  localparam logic [CNT_W-1:0] CNT_MAX = 15'h7FFF;

  localparam logic [1:0] CELL_EMPTY = 2'd0;
  localparam logic [1:0] CELL_TREE  = 2'd1;
  localparam logic [1:0] CELL_BURN  = 2'd2;

  localparam logic [1:0] CMD_INIT = 2'd0;
  localparam logic [1:0] CMD_GEN  = 2'd1;
  localparam logic [1:0] CMD_CLR  = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_SEED   = 3'd2;
  localparam logic [2:0] REG_GROW   = 3'd3;
  localparam logic [2:0] REG_LIGHT  = 3'd4;
  localparam logic [2:0] REG_FILL   = 3'd5;

  localparam logic [7:0]      RST_WIDTH  = 8'd128;
  localparam logic [7:0]      RST_HEIGHT = 8'd128;
  localparam logic [63:0]     RST_SEED   = 64'd20260609;
  localparam logic [TH_W-1:0] RST_GROW   = 54'd90071992547410;
  localparam logic [TH_W-1:0] RST_LIGHT  = 54'd9007199255;
  localparam logic [TH_W-1:0] RST_FILL   = 54'd4953959590107546;

  localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX1   = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX2   = 64'h94D049BB133111EB;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_SETUP,
    ST_INI_DRAW, ST_INI_WAIT,
    ST_G_RD, ST_G_CHK, ST_G_GDRAW, ST_G_GWAIT, ST_G_LDRAW, ST_G_LWAIT, ST_G_WR,
    ST_S_ROW, ST_S_ROW1, ST_S_A, ST_S_B, ST_S_C,
    ST_MCLR, ST_RD, ST_RD2, ST_CNT, ST_DONE
  } main_state_t;

  typedef enum logic [1:0] {
    DR_IDLE, DR_MUL, DR_CMP
  } draw_state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage
`default_nettype wire

@@ rtl/forest_fire_grid_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// forest_fire_grid_step
// forest fire cellular automaton with splitmix64 draws and an apb register port
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// beat appears on the result ports for one cycle with done high and cannot be
// held off. After reset the block sweeps the whole store with busy high. A
// random draw uses the shared 32x32 multiplier (three partial products for
// each of the two 64-bit multiplies). Initialize draws every cell in use; a
// generation counts the burning cells, applies growth and lightning, spreads
// the fire and counts the trees; clear mask sweeps the whole burn mask; read
// fetches one cell. Every command ends with a tree count.
module forest_fire_grid_step
  import ffgs_pkg::*;
#(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  wire  [1:0]          cmd,
  input  wire  [13:0]         cell_index,
  output logic                done,
  output logic [CNT_W-1:0]    burning_before,
  output logic [CNT_W-1:0]    burning_after,
  output logic [CNT_W-1:0]    lightning_count,
  output logic [CNT_W-1:0]    tree_count,
  output logic [1:0]          cell_value,
  output logic                cell_burned,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [ADDR_W-1:0]   paddr,
  input  wire  [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);

`include "forest_fire_grid_step_assert.svh"

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(DEPTH + 1);
  localparam int EW    = NW + 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int PW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW    = (NW > 14) ? NW : 14;

  // configuration registers
  logic [7:0]      num_cols;
  logic [7:0]      num_rows;
  logic [63:0]     seed;
  logic [TH_W-1:0] growth_threshold;
  logic [TH_W-1:0] lightning_threshold;
  logic [TH_W-1:0] fill_threshold;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols            <= RST_WIDTH;
      num_rows            <= RST_HEIGHT;
      seed                <= RST_SEED;
      growth_threshold    <= RST_GROW;
      lightning_threshold <= RST_LIGHT;
      fill_threshold      <= RST_FILL;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH:  num_cols            <= pwdata[7:0];
        REG_HEIGHT: num_rows            <= pwdata[7:0];
        REG_SEED:   seed                <= pwdata;
        REG_GROW:   growth_threshold    <= pwdata[TH_W-1:0];
        REG_LIGHT:  lightning_threshold <= pwdata[TH_W-1:0];
        REG_FILL:   fill_threshold      <= pwdata[TH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:  prdata = {56'd0, num_cols};
      REG_HEIGHT: prdata = {56'd0, num_rows};
      REG_SEED:   prdata = seed;
      REG_GROW:   prdata = {10'd0, growth_threshold};
      REG_LIGHT:  prdata = {10'd0, lightning_threshold};
      REG_FILL:   prdata = {10'd0, fill_threshold};
      default:    prdata = 64'd0;
    endcase
  end

  // grid size in use
  logic [WW-1:0]    w_sat, w_q;
  logic [HW-1:0]    h_sat, h_q;
  logic [WW+HW-1:0] n_full;
  logic [NW-1:0]    n_q;

  always_comb begin
    if (num_cols == 8'd0) begin
      w_sat = WW'(1);
    end else if (32'(num_cols) > MAX_WIDTH) begin
      w_sat = WW'(MAX_WIDTH);
    end else begin
      w_sat = WW'(num_cols);
    end
    if (num_rows == 8'd0) begin
      h_sat = HW'(1);
    end else if (32'(num_rows) > MAX_HEIGHT) begin
      h_sat = HW'(MAX_HEIGHT);
    end else begin
      h_sat = HW'(num_rows);
    end
  end

  assign n_full = (WW+HW)'(w_sat) * (WW+HW)'(h_sat);

  // state
  main_state_t state, state_next;
  draw_state_t dr_state, dr_next;

  logic [1:0]       cmd_q;
  logic [13:0]      ci_q;
  logic [NW-1:0]    idx;
  logic             pend;
  logic [CNT_W-1:0] cnt;
  logic             cnt_burn;
  logic [1:0]       cur_s;
  logic [HW-1:0]    r;
  logic [WW-1:0]    c;
  logic [NW-1:0]    row_base;
  logic [1:0]       left, mid, right;

  // memories
  logic [1:0] cell_mem [DEPTH];
  logic       burn_mem [DEPTH];
  logic [1:0] prev_mem [MAX_WIDTH];

  logic          cell_we, burn_we, burn_wdata, prev_we;
  logic [AW-1:0] cell_waddr, burn_waddr, rd_addr;
  logic [1:0]    cell_wdata;
  logic [1:0]    rdata, prev_q;
  logic          bdata;

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    rdata <= cell_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (burn_we) begin
      burn_mem[burn_waddr] <= burn_wdata;
    end
    bdata <= burn_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[c[PW-1:0]] <= mid;
    end
    prev_q <= prev_mem[c[PW-1:0]];
  end

  // addresses and flags
  logic [EW-1:0] a_right, a_below, a_cur;
  logic [CW-1:0] ci_ext;
  logic          ci_ok, last, sweep_last, cnt_end, c_last, r_last, hot;
  logic [1:0]    spread_s;

  assign a_cur      = EW'(row_base) + EW'(c);
  assign a_right    = a_cur + EW'(1);
  assign a_below    = a_cur + EW'(w_q);
  assign ci_ext     = CW'(ci_q);
  assign ci_ok      = ci_ext < CW'(n_q);
  assign last       = idx == (n_q - 1'b1);
  assign sweep_last = idx == NW'(DEPTH - 1);
  assign cnt_end    = (idx == n_q) && !pend;
  assign c_last     = c == (w_q - 1'b1);
  assign r_last     = r == (h_q - 1'b1);

  assign hot = ((r != '0) && (prev_q == CELL_BURN)) ||
               (!r_last && (rdata == CELL_BURN)) ||
               ((c != '0) && (left == CELL_BURN)) ||
               (!c_last && (right == CELL_BURN));

  always_comb begin
    if (mid == CELL_BURN) begin
      spread_s = CELL_EMPTY;
    end else if (mid == CELL_TREE) begin
      spread_s = hot ? CELL_BURN : CELL_TREE;
    end else begin
      spread_s = mid;
    end
  end

  // random draw unit
  logic            draw_go, dr_done, dr_hit;
  logic [63:0]     rng, z, acc, s_add, z0, mk, prod, term, sum, fin;
  logic [31:0]     ma, mb;
  logic [1:0]      ph;
  logic            stage;
  logic [TH_W-1:0] th;

  assign s_add = rng + GOLDEN;
  assign z0    = s_add ^ (s_add >> 30);
  assign mk    = stage ? MIX2 : MIX1;
  assign ma    = (ph == 2'd2) ? z[63:32] : z[31:0];
  assign mb    = (ph == 2'd1) ? mk[63:32] : mk[31:0];
  assign prod  = 64'(ma) * 64'(mb);
  assign term  = (ph == 2'd0) ? prod : {prod[31:0], 32'd0};
  assign sum   = acc + term;
  assign fin   = sum ^ (sum >> 31);

  always_comb begin
    unique case (state)
      ST_INI_WAIT: th = fill_threshold;
      ST_G_GWAIT:  th = growth_threshold;
      default:     th = lightning_threshold;
    endcase
  end

  assign dr_done = dr_state == DR_CMP;
  assign dr_hit  = {1'b0, z[52:0]} < th;

  always_ff @(posedge clk) begin
    if (rst) begin
      dr_state <= DR_IDLE;
    end else begin
      dr_state <= dr_next;
    end
  end

  always_comb begin
    dr_next = dr_state;
    unique case (dr_state)
      DR_IDLE: if (draw_go) dr_next = DR_MUL;
      DR_MUL:  if (ph == 2'd2 && stage) dr_next = DR_CMP;
      DR_CMP:  dr_next = DR_IDLE;
      default: dr_next = DR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rng   <= 64'd0;
      ph    <= 2'd0;
      stage <= 1'b0;
    end else if (state == ST_SETUP && cmd_q == CMD_INIT) begin
      rng <= seed;
    end else if (dr_state == DR_IDLE) begin
      ph    <= 2'd0;
      stage <= 1'b0;
      acc   <= 64'd0;
      if (draw_go) begin
        rng <= s_add;
        z   <= z0;
      end
    end else if (dr_state == DR_MUL) begin
      if (ph == 2'd2) begin
        ph    <= 2'd0;
        stage <= 1'b1;
        acc   <= 64'd0;
        if (stage) begin
          z <= {11'd0, fin[63:11]};
        end else begin
          z <= sum ^ (sum >> 27);
        end
      end else begin
        ph  <= ph + 2'd1;
        acc <= sum;
      end
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = state != ST_IDLE;
  assign done = state == ST_DONE;

  always_comb begin
    state_next = state;
    cell_we    = 1'b0;
    cell_waddr = idx[AW-1:0];
    cell_wdata = CELL_EMPTY;
    burn_we    = 1'b0;
    burn_waddr = idx[AW-1:0];
    burn_wdata = 1'b0;
    rd_addr    = idx[AW-1:0];
    prev_we    = 1'b0;
    draw_go    = 1'b0;
    unique case (state)
      ST_CLR: begin
        cell_we = 1'b1;
        burn_we = 1'b1;
        if (sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: if (start) state_next = ST_SETUP;
      ST_SETUP: begin
        unique case (cmd_q)
          CMD_INIT: state_next = ST_INI_DRAW;
          CMD_GEN:  state_next = ST_CNT;
          CMD_CLR:  state_next = ST_MCLR;
          CMD_READ: state_next = ST_RD;
          default:  state_next = ST_IDLE;
        endcase
      end
      ST_INI_DRAW: begin
        draw_go    = 1'b1;
        state_next = ST_INI_WAIT;
      end
      ST_INI_WAIT: begin
        if (dr_done) begin
          cell_we    = 1'b1;
          cell_wdata = dr_hit ? CELL_TREE : CELL_EMPTY;
          state_next = last ? ST_CNT : ST_INI_DRAW;
        end
      end
      ST_G_RD: state_next = ST_G_CHK;
      ST_G_CHK: begin
        if (rdata == CELL_EMPTY) begin
          state_next = ST_G_GDRAW;
        end else if (rdata == CELL_TREE) begin
          state_next = ST_G_LDRAW;
        end else begin
          state_next = ST_G_WR;
        end
      end
      ST_G_GDRAW: begin
        draw_go    = 1'b1;
        state_next = ST_G_GWAIT;
      end
      ST_G_GWAIT: if (dr_done) state_next = dr_hit ? ST_G_LDRAW : ST_G_WR;
      ST_G_LDRAW: begin
        draw_go    = 1'b1;
        state_next = ST_G_LWAIT;
      end
      ST_G_LWAIT: if (dr_done) state_next = ST_G_WR;
      ST_G_WR: begin
        cell_we    = 1'b1;
        cell_wdata = cur_s;
        state_next = last ? ST_S_ROW : ST_G_RD;
      end
      ST_S_ROW: begin
        rd_addr    = row_base[AW-1:0];
        state_next = ST_S_ROW1;
      end
      ST_S_ROW1: state_next = ST_S_A;
      ST_S_A: begin
        rd_addr    = a_right[AW-1:0];
        state_next = ST_S_B;
      end
      ST_S_B: begin
        rd_addr    = a_below[AW-1:0];
        state_next = ST_S_C;
      end
      ST_S_C: begin
        cell_we    = 1'b1;
        cell_waddr = a_cur[AW-1:0];
        cell_wdata = spread_s;
        burn_we    = mid == CELL_BURN;
        burn_waddr = a_cur[AW-1:0];
        burn_wdata = 1'b1;
        prev_we    = 1'b1;
        if (c_last) begin
          state_next = r_last ? ST_CNT : ST_S_ROW;
        end else begin
          state_next = ST_S_A;
        end
      end
      ST_MCLR: begin
        burn_we = 1'b1;
        if (sweep_last) state_next = ST_CNT;
      end
      ST_RD: begin
        rd_addr    = ci_ext[AW-1:0];
        state_next = ST_RD2;
      end
      ST_RD2: state_next = ST_CNT;
      ST_CNT: if (cnt_end) state_next = cnt_burn ? ST_G_RD : ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      pend     <= 1'b0;
      cnt      <= '0;
      cnt_burn <= 1'b0;
    end else begin
      unique case (state)
        ST_CLR, ST_MCLR: idx <= sweep_last ? '0 : idx + 1'b1;
        ST_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            ci_q  <= cell_index;
          end
        end
        ST_SETUP: begin
          w_q             <= w_sat;
          h_q             <= h_sat;
          n_q             <= NW'(n_full);
          idx             <= '0;
          pend            <= 1'b0;
          cnt             <= '0;
          cnt_burn        <= cmd_q == CMD_GEN;
          burning_before  <= '0;
          burning_after   <= '0;
          lightning_count <= '0;
          cell_value      <= CELL_EMPTY;
          cell_burned     <= 1'b0;
        end
        ST_INI_WAIT: if (dr_done) idx <= last ? '0 : idx + 1'b1;
        ST_G_CHK: cur_s <= rdata;
        ST_G_GWAIT: if (dr_done && dr_hit) cur_s <= CELL_TREE;
        ST_G_LWAIT: begin
          if (dr_done && dr_hit) begin
            cur_s           <= CELL_BURN;
            lightning_count <= sat_inc(lightning_count);
          end
        end
        ST_G_WR: begin
          if (last) begin
            idx      <= '0;
            r        <= '0;
            row_base <= '0;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_S_ROW: c <= '0;
        ST_S_ROW1: mid <= rdata;
        ST_S_B: right <= rdata;
        ST_S_C: begin
          left <= mid;
          mid  <= right;
          if (mid == CELL_TREE && hot) burning_after <= sat_inc(burning_after);
          if (c_last) begin
            c        <= '0;
            r        <= r + 1'b1;
            row_base <= row_base + NW'(w_q);
          end else begin
            c <= c + 1'b1;
          end
        end
        ST_RD2: begin
          if (ci_ok) begin
            cell_value  <= rdata;
            cell_burned <= bdata;
          end
        end
        ST_CNT: begin
          if (cnt_end) begin
            idx <= '0;
            cnt <= '0;
            if (cnt_burn) begin
              burning_before <= cnt;
              cnt_burn       <= 1'b0;
            end else begin
              tree_count <= cnt;
            end
          end else begin
            if (idx != n_q) begin
              idx  <= idx + 1'b1;
              pend <= 1'b1;
            end else begin
              pend <= 1'b0;
            end
            if (pend && rdata == (cnt_burn ? CELL_BURN : CELL_TREE)) begin
              cnt <= sat_inc(cnt);
            end
          end
        end
        default: ;
      endcase
    end
  end

  `FFGS_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `FFGS_ASSERT_NXT(a_done_release, done, !busy)
  `FFGS_ASSERT_IMP(a_draw_quiet, state == ST_IDLE, dr_state == DR_IDLE)

endmodule
`default_nettype wire
